@@ src/acmp_pkg.sv @@
package acmp_pkg;

  localparam int unsigned POS_INPUTS_DEF = 8;
  localparam int unsigned NEG_INPUTS_DEF = 8;
  localparam int unsigned LEVEL_BITS_DEF = 16;

  localparam int unsigned CHAN_BITS     = 3;
  localparam int unsigned FIELD_BITS    = 16;
  localparam int unsigned VCC_BITS      = 16;
  localparam int unsigned VCC_RESET_MV  = 3300;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned HYST_MV_BITS  = 6;
  localparam int unsigned HYST_ENTRIES  = 8;
  localparam int unsigned HYST_IDX_BITS = 3;

  // Indexed by {low_power, hyst_mode}, millivolts.
  localparam logic [HYST_MV_BITS-1:0] HYST_MV [HYST_ENTRIES] = '{
    6'd0, 6'd10, 6'd30, 6'd60,
    6'd0, 6'd10, 6'd25, 6'd50
  };

  typedef enum logic [2:0] {
    MODE_LEVEL  = 3'd0,
    MODE_VCC    = 3'd1,
    MODE_INTREF = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_SLEEP  = 3'd4,
    MODE_EVAL   = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CONTROL_A = 3'd0,
    CFG_MUX       = 3'd1,
    CFG_DAC_REF   = 3'd2,
    CFG_IRQ_EN    = 3'd3,
    CFG_POS_KINDS = 3'd4,
    CFG_NEG_KINDS = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EDGE_BOTH = 2'd0,
    EDGE_NONE = 2'd1,
    EDGE_FALL = 2'd2,
    EDGE_RISE = 2'd3
  } edge_e;

  typedef enum logic [1:0] {
    KIND_LEVEL  = 2'd0,
    KIND_DAC    = 2'd1,
    KIND_INTREF = 2'd2,
    KIND_ZERO   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0]            mode;
    logic                  side;
    logic [CHAN_BITS-1:0]  channel;
    logic [FIELD_BITS-1:0] level;
    logic                  sleep_on;
    logic [1:0]            sleep_depth;
  } in_t;

  typedef struct packed {
    logic                  compare_out;
    logic                  compare_flag;
    logic                  irq_request;
    logic [FIELD_BITS-1:0] dac_ref_out;
    logic                  bad_select;
  } out_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic div_start;
    logic div_step;
    logic div_done;
  } cmd_t;

endpackage

@@ src/analog_comparator_hysteresis_irq_core.sv @@
// Analog comparator with hysteresis and edge interrupt. Every input
// transaction yields exactly one result transaction, held in an output
// register so the next input can be taken while it waits. Items are handled
// one at a time: a channel level, intref, clear, sleep or reevaluate
// transaction goes through an execute state, waiting there while the prior
// result is still held; a VCC change also runs the bit-serial restoring
// dividers that recompute the hysteresis fractions for all table entries,
// one quotient bit per cycle, before its result is loaded. Configuration
// writes take effect in the cycle they are written, including any hysteresis
// update and re-evaluation, and must only be issued while the block is idle.
module analog_comparator_hysteresis_irq_core #(
  parameter int unsigned POS_INPUTS = acmp_pkg::POS_INPUTS_DEF,
  parameter int unsigned NEG_INPUTS = acmp_pkg::NEG_INPUTS_DEF,
  parameter int unsigned LEVEL_BITS = acmp_pkg::LEVEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  acmp_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output acmp_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [acmp_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [acmp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  acmp_pkg::cmd_t cmd;
  logic           is_vcc;

  acmp_ctrl #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_vcc_i   (is_vcc),
    .cmd_o      (cmd)
  );

  acmp_dp #(
    .POS_INPUTS(POS_INPUTS),
    .NEG_INPUTS(NEG_INPUTS),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .is_vcc_o   (is_vcc),
    .out_data_o (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after a transaction");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in progress");

  a_irq_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.irq_request || out_data_o.compare_flag))
    else $error("irq request without compare flag");

endmodule

@@ src/acmp_ctrl.sv @@
module acmp_ctrl #(
  parameter int unsigned LEVEL_BITS = acmp_pkg::LEVEL_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic            is_vcc_i,
  output acmp_pkg::cmd_t  cmd_o
);

  localparam int unsigned QuotBits = acmp_pkg::HYST_MV_BITS + LEVEL_BITS;
  localparam int unsigned CntBits  = $clog2(QuotBits);
  localparam logic [CntBits-1:0] CntLast = CntBits'(QuotBits - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 load;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_vcc_i) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end else if (out_free) begin
          cmd_o.exec = 1'b1;
          load       = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.div_done = 1'b1;
          load           = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/acmp_dp.sv @@
module acmp_dp #(
  parameter int unsigned POS_INPUTS = acmp_pkg::POS_INPUTS_DEF,
  parameter int unsigned NEG_INPUTS = acmp_pkg::NEG_INPUTS_DEF,
  parameter int unsigned LEVEL_BITS = acmp_pkg::LEVEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  acmp_pkg::cmd_t                       cmd_i,
  input  acmp_pkg::in_t                        in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [acmp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [acmp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  output logic                                 is_vcc_o,
  output acmp_pkg::out_t                       out_data_o
);

  localparam int unsigned PosIdxBits = (POS_INPUTS > 1) ? $clog2(POS_INPUTS) : 1;
  localparam int unsigned NegIdxBits = (NEG_INPUTS > 1) ? $clog2(NEG_INPUTS) : 1;
  localparam int unsigned QuotBits   = acmp_pkg::HYST_MV_BITS + LEVEL_BITS;
  localparam int unsigned ProdBits   = LEVEL_BITS + 8;
  localparam int unsigned DiffBits   = LEVEL_BITS + 2;
  localparam int unsigned VccBits    = acmp_pkg::VCC_BITS;
  localparam logic [LEVEL_BITS-1:0] LevelMax = '1;

  typedef logic [LEVEL_BITS-1:0] level_t;

  acmp_pkg::in_t   in_q;
  acmp_pkg::out_t  out_q, out_d;

  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mux_q, mux_d;
  logic [7:0]  dacref_q, dacref_d;
  logic        irqen_q, irqen_d;
  logic [15:0] pkind_q, pkind_d;
  logic [15:0] nkind_q, nkind_d;

  level_t pos_lvl_q [POS_INPUTS];
  level_t pos_lvl_d [POS_INPUTS];
  level_t neg_lvl_q [NEG_INPUTS];
  level_t neg_lvl_d [NEG_INPUTS];

  logic [VccBits-1:0] vcc_q, vcc_d;
  level_t             intref_q, intref_d;
  level_t             hyst_q, hyst_d;
  logic               raw_q, raw_d;
  logic               ost_q, ost_d;
  logic               flag_q, flag_d;
  logic               asleep_q, asleep_d;

  logic [VccBits-1:0]  rem_q [acmp_pkg::HYST_ENTRIES];
  logic [QuotBits-1:0] dq_q  [acmp_pkg::HYST_ENTRIES];
  level_t              hq_q  [acmp_pkg::HYST_ENTRIES];
  level_t              lane_frac [acmp_pkg::HYST_ENTRIES];

  logic                               do_eval;
  logic                               hyst_upd;
  logic [acmp_pkg::HYST_IDX_BITS-1:0] hidx;
  level_t                             lvl_in;
  logic [ProdBits-1:0]                prod;
  level_t                             dac_lvl;
  logic [acmp_pkg::CHAN_BITS-1:0]     pos_sel, neg_sel;
  logic [1:0]                         pkind, nkind;
  logic                               bad;
  level_t                             pos_v, neg_v;
  logic signed [DiffBits-1:0]         diff, hs;
  logic                               new_out, edge_hit;

  assign lvl_in   = LEVEL_BITS'(in_q.level);
  assign is_vcc_o = (in_q.mode == acmp_pkg::MODE_VCC);

  // Bit-serial restoring dividers, one lane per hysteresis table entry.
  for (genvar g = 0; g < acmp_pkg::HYST_ENTRIES; g++) begin : g_lane
    localparam logic [63:0] RstQuot =
      (64'(acmp_pkg::HYST_MV[g]) << LEVEL_BITS) / 64'(acmp_pkg::VCC_RESET_MV);
    localparam level_t RstFrac =
      (RstQuot > 64'(LevelMax)) ? LevelMax : LEVEL_BITS'(RstQuot);

    logic [VccBits:0] rem_ext, rem_sub;
    logic             ge;

    assign rem_ext = {rem_q[g], dq_q[g][QuotBits-1]};
    assign ge      = (rem_ext >= {1'b0, vcc_q});
    assign rem_sub = ge ? (rem_ext - {1'b0, vcc_q}) : rem_ext;
    assign lane_frac[g] = (|dq_q[g][QuotBits-1:LEVEL_BITS]) ? LevelMax
                                                            : dq_q[g][LEVEL_BITS-1:0];

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_start) begin
        rem_q[g] <= '0;
        dq_q[g]  <= QuotBits'(acmp_pkg::HYST_MV[g]) << LEVEL_BITS;
      end else if (cmd_i.div_step) begin
        rem_q[g] <= rem_sub[VccBits-1:0];
        dq_q[g]  <= {dq_q[g][QuotBits-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hq_q[g] <= RstFrac;
      end else if (cmd_i.div_done) begin
        hq_q[g] <= lane_frac[g];
      end
    end
  end

  always_comb begin
    ctrl_d    = ctrl_q;
    mux_d     = mux_q;
    dacref_d  = dacref_q;
    irqen_d   = irqen_q;
    pkind_d   = pkind_q;
    nkind_d   = nkind_q;
    pos_lvl_d = pos_lvl_q;
    neg_lvl_d = neg_lvl_q;
    vcc_d     = vcc_q;
    intref_d  = intref_q;
    hyst_d    = hyst_q;
    raw_d     = raw_q;
    ost_d     = ost_q;
    flag_d    = flag_q;
    asleep_d  = asleep_q;
    do_eval   = 1'b0;
    hyst_upd  = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acmp_pkg::CFG_CONTROL_A: begin
          ctrl_d   = cfg_wdata_i[7:0];
          hyst_upd = cfg_wdata_i[0];
          do_eval  = 1'b1;
        end
        acmp_pkg::CFG_MUX: begin
          mux_d   = cfg_wdata_i[7:0];
          do_eval = 1'b1;
        end
        acmp_pkg::CFG_DAC_REF: begin
          dacref_d = cfg_wdata_i[7:0];
          do_eval  = 1'b1;
        end
        acmp_pkg::CFG_IRQ_EN:    irqen_d = cfg_wdata_i[0];
        acmp_pkg::CFG_POS_KINDS: pkind_d = cfg_wdata_i;
        acmp_pkg::CFG_NEG_KINDS: nkind_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (cmd_i.exec) begin
      unique case (in_q.mode)
        acmp_pkg::MODE_LEVEL: begin
          if (!in_q.side) begin
            if (int'(in_q.channel) < POS_INPUTS) begin
              pos_lvl_d[in_q.channel[PosIdxBits-1:0]] = lvl_in;
              do_eval = (in_q.channel == mux_q[5:3]);
            end
          end else begin
            if (int'(in_q.channel) < NEG_INPUTS) begin
              neg_lvl_d[in_q.channel[NegIdxBits-1:0]] = lvl_in;
              do_eval = (in_q.channel == mux_q[2:0]);
            end
          end
        end
        acmp_pkg::MODE_INTREF: begin
          intref_d = lvl_in;
          do_eval  = 1'b1;
        end
        acmp_pkg::MODE_CLEAR: flag_d = 1'b0;
        acmp_pkg::MODE_SLEEP: begin
          if ((in_q.sleep_depth >= 2'd2) || ((in_q.sleep_depth == 2'd1) && !ctrl_q[7])) begin
            asleep_d = in_q.sleep_on;
          end
        end
        acmp_pkg::MODE_EVAL: do_eval = 1'b1;
        default: ;
      endcase
    end

    if (cmd_i.div_start) begin
      vcc_d = in_q.level;
    end

    if (cmd_i.div_done) begin
      hyst_upd = ctrl_q[0];
      do_eval  = 1'b1;
    end

    hidx = {ctrl_d[3], ctrl_d[2:1]};
    if (hyst_upd) begin
      if (acmp_pkg::HYST_MV[hidx] == '0) begin
        hyst_d = '0;
      end else begin
        hyst_d = cmd_i.div_done ? lane_frac[hidx] : hq_q[hidx];
      end
    end

    prod    = intref_d * ProdBits'(dacref_d);
    dac_lvl = prod[ProdBits-1:8];

    pos_sel = mux_d[5:3];
    neg_sel = mux_d[2:0];
    bad     = (int'(pos_sel) >= POS_INPUTS) || (int'(neg_sel) >= NEG_INPUTS);
    pkind   = pkind_q[{pos_sel, 1'b0} +: 2];
    nkind   = nkind_q[{neg_sel, 1'b0} +: 2];

    unique case (pkind)
      acmp_pkg::KIND_LEVEL:  pos_v = pos_lvl_d[pos_sel[PosIdxBits-1:0]];
      acmp_pkg::KIND_DAC:    pos_v = dac_lvl;
      acmp_pkg::KIND_INTREF: pos_v = intref_d;
      acmp_pkg::KIND_ZERO:   pos_v = '0;
      default:               pos_v = '0;
    endcase
    unique case (nkind)
      acmp_pkg::KIND_LEVEL:  neg_v = neg_lvl_d[neg_sel[NegIdxBits-1:0]];
      acmp_pkg::KIND_DAC:    neg_v = dac_lvl;
      acmp_pkg::KIND_INTREF: neg_v = intref_d;
      acmp_pkg::KIND_ZERO:   neg_v = '0;
      default:               neg_v = '0;
    endcase

    diff = $signed({2'b00, pos_v}) - $signed({2'b00, neg_v});
    hs   = $signed({2'b00, hyst_d});

    // Hysteresis acts on the uninverted state.
    if (raw_q && (diff < -hs)) begin
      new_out = mux_d[7];
    end else if (!raw_q && (diff > hs)) begin
      new_out = !mux_d[7];
    end else begin
      new_out = raw_q ^ mux_d[7];
    end

    unique case (ctrl_d[5:4])
      acmp_pkg::EDGE_BOTH: edge_hit = (new_out != ost_q);
      acmp_pkg::EDGE_NONE: edge_hit = 1'b0;
      acmp_pkg::EDGE_FALL: edge_hit = ost_q && !new_out;
      acmp_pkg::EDGE_RISE: edge_hit = !ost_q && new_out;
      default:             edge_hit = 1'b0;
    endcase

    if (do_eval && !asleep_q && !bad) begin
      if (!ctrl_d[0]) begin
        raw_d = 1'b0;
        ost_d = 1'b0;
      end else begin
        raw_d = new_out ^ mux_d[7];
        ost_d = new_out;
        if (edge_hit) begin
          flag_d = 1'b1;
        end
      end
    end

    out_d.compare_out  = ost_d;
    out_d.compare_flag = flag_d;
    out_d.irq_request  = flag_d & irqen_q;
    out_d.dac_ref_out  = acmp_pkg::FIELD_BITS'(dac_lvl);
    out_d.bad_select   = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '0;
      mux_q     <= '0;
      dacref_q  <= '0;
      irqen_q   <= 1'b0;
      pkind_q   <= '0;
      nkind_q   <= '0;
      pos_lvl_q <= '{default: '0};
      neg_lvl_q <= '{default: '0};
      vcc_q     <= VccBits'(acmp_pkg::VCC_RESET_MV);
      intref_q  <= '0;
      hyst_q    <= '0;
      raw_q     <= 1'b0;
      ost_q     <= 1'b0;
      flag_q    <= 1'b0;
      asleep_q  <= 1'b0;
    end else begin
      ctrl_q    <= ctrl_d;
      mux_q     <= mux_d;
      dacref_q  <= dacref_d;
      irqen_q   <= irqen_d;
      pkind_q   <= pkind_d;
      nkind_q   <= nkind_d;
      pos_lvl_q <= pos_lvl_d;
      neg_lvl_q <= neg_lvl_d;
      vcc_q     <= vcc_d;
      intref_q  <= intref_d;
      hyst_q    <= hyst_d;
      raw_q     <= raw_d;
      ost_q     <= ost_d;
      flag_q    <= flag_d;
      asleep_q  <= asleep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.exec || cmd_i.div_done) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
